// ===== src/sha_pkg.sv =====
// package: sha-256 constants, round function helpers and front-to-back job type
package sha_pkg;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
		32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

	localparam logic [7:0] PAD_MARK = 8'h80;

	// one block for the compressor: final marks the last block of a message
	typedef struct packed {
		logic [511:0] words;
		logic         final_blk;
	} job_t;

	function automatic logic [31:0] ror(input logic [31:0] v, input int s);
		ror = (v >> s) | (v << (32 - s));
	endfunction

endpackage

// ===== src/sha_if.sv =====
// valid/ready channel interface
interface sha_if #(parameter int W = 8) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/sha256_stream_hasher.sv =====
// top level: streaming sha-256 hasher over a byte channel
// Bytes are taken one a cycle into the current 64-byte block while the queue is empty and
// no length block is owed; when a block fills, it moves to a two-entry queue and the input
// stalls until the queue is empty again. The compressor loads a block, runs 64 rounds and
// adds the result into the hash, so a full block waits in the queue, with the input stalled,
// until the compressor is idle and takes it. After the last byte of a message, the padding
// and length go into its last block, or into one extra block when they do not fit, and
// the eight digest words come out in order, word 0 first, with last_word on word 7.
module sha256_stream_hasher (
	input logic clk,
	input logic arst_n,
	sha_if.sink   in_ch,
	sha_if.source out_ch
);
	logic          job_valid, job_ready;
	sha_pkg::job_t job;

	sha_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.data_byte(in_ch.data[7:0]), .has_byte(in_ch.data[8]), .last_byte(in_ch.data[9]),
		.job_valid, .job_ready, .job
	);

	sha_back u_back (
		.clk, .arst_n,
		.job_valid, .job_ready, .job,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.digest_word(out_ch.data[31:0]), .word_index(out_ch.data[34:32]),
		.last_word(out_ch.data[35])
	);
endmodule

// ===== src/sha_front.sv =====
// front part: packs bytes into blocks, pads and pushes jobs into a two-deep queue
module sha_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          has_byte,
	input  logic          last_byte,
	output logic          job_valid,
	input  logic          job_ready,
	output sha_pkg::job_t job
);
	logic [31:0] blk_q [16];
	logic [60:0] len_q;
	logic        pend_q;       // length block still owed after padding overflow
	logic        pend_mark_q;  // owed block also starts with the pad marker
	sha_pkg::job_t fifo_q [2];
	logic [1:0]  cnt_q;
	logic        rd_q;
	logic        wr_q;

	logic        push, pop;
	logic [60:0] len_n;
	logic [5:0]  pos;
	logic [31:0] nb [16];
	logic [511:0] flat;
	logic        full_blk, pad_blk, two;
	sha_pkg::job_t push_job;

	assign pop       = job_valid && job_ready;
	assign job_valid = cnt_q != 2'd0;
	assign job       = fifo_q[rd_q];
	// an item may need two blocks, so two free slots are required
	assign in_ready  = !pend_q && cnt_q == 2'd0;
	assign push      = (pend_q && cnt_q != 2'd2)
		|| (in_valid && in_ready && (full_blk || pad_blk || two));

	always_comb begin
		logic [5:0] p;
		nb = blk_q;
		p = len_q[5:0];
		len_n = len_q;
		full_blk = 1'b0;
		pad_blk = 1'b0;
		two = 1'b0;
		if (has_byte) begin
			if (p[1:0] == 2'd0) nb[p[5:2]] = {data_byte, 24'd0};
			else nb[p[5:2]][5'd24 - {p[1:0], 3'd0} +: 8] = data_byte;
			len_n = len_q + 61'd1;
			full_blk = len_n[5:0] == 6'd0;
		end
		pos = len_n[5:0];
		if (last_byte && !full_blk) begin
			if (pos[1:0] == 2'd0) nb[pos[5:2]] = {sha_pkg::PAD_MARK, 24'd0};
			else nb[pos[5:2]][5'd24 - {pos[1:0], 3'd0} +: 8] = sha_pkg::PAD_MARK;
			for (int i = 0; i < 16; i++)
				if (4'(i) > pos[5:2]) nb[i] = '0;
			if (pos >= 6'd56) two = 1'b1;
			else begin
				nb[14] = {len_n[60:29]};
				nb[15] = {len_n[28:0], 3'd0};
				pad_blk = 1'b1;
			end
		end
		for (int i = 0; i < 16; i++) flat[511-32*i -: 32] = nb[i];
		push_job.words = flat;
		push_job.final_blk = pad_blk;
	end

	logic [511:0] len_blk;
	always_comb begin
		len_blk = '0;
		len_blk[511:504] = pend_mark_q ? sha_pkg::PAD_MARK : 8'h00;
		len_blk[63:0] = {len_q[60:0], 3'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pend_q <= 1'b0;
			pend_mark_q <= 1'b0;
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (pend_q && cnt_q != 2'd2) begin
				fifo_q[wr_q] <= '{words: len_blk, final_blk: 1'b1};
				wr_q <= !wr_q;
				pend_q <= 1'b0;
				len_q <= '0;
			end else if (in_valid && in_ready) begin
				blk_q <= nb;
				len_q <= len_n;
				if (full_blk || pad_blk || two) begin
					fifo_q[wr_q] <= push_job;
					wr_q <= !wr_q;
				end
				if (last_byte) begin
					if (full_blk || two) begin
						pend_q <= 1'b1;
						pend_mark_q <= full_blk;
					end else len_q <= '0;
				end
			end
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (!push && pop) cnt_q <= cnt_q - 2'd1;
			if (pop) rd_q <= !rd_q;
		end
	end
endmodule

// ===== src/sha_back.sv =====
// back part: 64-round compressor with on-the-fly schedule and digest output register
module sha_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  sha_pkg::job_t job,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          last_word
);
	localparam logic [1:0] ST_IDLE = 2'd0, ST_RUN = 2'd1, ST_ADD = 2'd2, ST_OUT = 2'd3;
	logic [1:0]  state_q;
	logic [5:0]  rnd_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic        fin_q;
	logic [2:0]  idx_q;

	logic [31:0] t1, t2, wn, s0, s1, e, a;
	assign e  = v_q[4];
	assign a  = v_q[0];
	assign s0 = sha_pkg::ror(w_q[1], 7) ^ sha_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = sha_pkg::ror(w_q[14], 17) ^ sha_pkg::ror(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = v_q[7] + (sha_pkg::ror(e, 6) ^ sha_pkg::ror(e, 11) ^ sha_pkg::ror(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::ROUND_K[rnd_q] + w_q[0];
	assign t2 = (sha_pkg::ror(a, 2) ^ sha_pkg::ror(a, 13) ^ sha_pkg::ror(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	assign job_ready   = state_q == ST_IDLE;
	assign out_valid   = state_q == ST_OUT;
	assign digest_word = h_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = idx_q == 3'd7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			idx_q <= '0;
			fin_q <= 1'b0;
			h_q <= sha_pkg::INIT_HASH;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) begin
					for (int i = 0; i < 16; i++) w_q[i] <= job.words[511-32*i -: 32];
					v_q <= h_q;
					fin_q <= job.final_blk;
					rnd_q <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					idx_q <= '0;
					state_q <= fin_q ? ST_OUT : ST_IDLE;
				end
				ST_OUT: if (out_ready) begin
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						h_q <= sha_pkg::INIT_HASH;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
